/* hdl/sdspi_pkg.sv */
// sdspi_pkg: shared types and constants for the SD card SPI-mode command engine.
// No dependencies; used by every module under hdl/.
package sdspi_pkg;

	// protocol constants
	localparam int unsigned RESP_WAIT_BYTES = 8;
	localparam int unsigned MAX_BLOCKS      = 256;

	localparam logic [7:0]  CMD_START   = 8'h40;
	localparam logic [7:0]  CMD_CRC     = 8'h95;
	localparam logic [7:0]  TOKEN_START = 8'hFE;
	localparam logic [7:0]  BYTE_FILL   = 8'hFF;
	localparam logic [7:0]  BYTE_ZERO   = 8'h00;
	localparam logic [4:0]  DRESP_CRC   = 5'h0B;
	localparam logic [4:0]  DRESP_WERR  = 5'h0D;
	localparam logic [31:0] ADDR_STEP   = 32'd512;

	// command indexes
	localparam logic [5:0] CMD9  = 6'd9;
	localparam logic [5:0] CMD10 = 6'd10;
	localparam logic [5:0] CMD12 = 6'd12;
	localparam logic [5:0] CMD13 = 6'd13;
	localparam logic [5:0] CMD17 = 6'd17;
	localparam logic [5:0] CMD18 = 6'd18;
	localparam logic [5:0] CMD24 = 6'd24;
	localparam logic [5:0] CMD28 = 6'd28;
	localparam logic [5:0] CMD29 = 6'd29;
	localparam logic [5:0] CMD38 = 6'd38;

	// item opcodes
	localparam logic OP_START = 1'b0;
	localparam logic OP_SLOT  = 1'b1;

	// status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NO_RESP  = 3'd1;
	localparam logic [2:0] ST_NO_TOKEN = 3'd2;
	localparam logic [2:0] ST_CRC_REJ  = 3'd3;
	localparam logic [2:0] ST_WR_ERR   = 3'd4;
	localparam logic [2:0] ST_BUSY_TO  = 3'd5;

	// register map (word index)
	localparam logic [1:0] REG_BLOCK_LEN  = 2'd0;
	localparam logic [1:0] REG_TOKEN_WAIT = 2'd1;
	localparam logic [1:0] REG_BUSY_WAIT  = 2'd2;

	localparam logic [11:0] BLOCK_LEN_RST  = 12'd512;
	localparam logic [15:0] TOKEN_WAIT_RST = 16'd8192;
	localparam logic [31:0] BUSY_WAIT_RST  = 32'd0;

	typedef struct packed {
		logic [11:0] block_len;
		logic [15:0] token_wait_limit;
		logic [31:0] busy_wait_limit;
	} cfg_t;

	typedef struct packed {
		logic        op;
		logic [5:0]  cmd;
		logic [31:0] arg;
		logic [8:0]  block_count;
		logic [7:0]  miso_byte;
		logic [7:0]  wdata_byte;
	} item_t;

	typedef struct packed {
		logic [7:0]  mosi_byte;
		logic        cs_active;
		logic        rd_valid;
		logic [7:0]  rd_byte;
		logic        wdata_taken;
		logic        done_res;
		logic [2:0]  status;
		logic [15:0] response;
	} res_t;

endpackage

/* hdl/sdspi_cfg.sv */
// sdspi_cfg: APB register file for block length and wait limits.
// Depends on sdspi_pkg.
module sdspi_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output sdspi_pkg::cfg_t     cfg
);

	logic [11:0] block_len_q;
	logic [15:0] token_wait_q;
	logic [31:0] busy_wait_q;
	logic        wr_en;
	logic [1:0]  reg_idx;

	// byte lanes within a word are not decoded
	assign reg_idx = paddr[3:2];
	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_len_q  <= sdspi_pkg::BLOCK_LEN_RST;
			token_wait_q <= sdspi_pkg::TOKEN_WAIT_RST;
			busy_wait_q  <= sdspi_pkg::BUSY_WAIT_RST;
		end else if (wr_en) begin
			case (reg_idx)
				sdspi_pkg::REG_BLOCK_LEN:  block_len_q  <= pwdata[11:0];
				sdspi_pkg::REG_TOKEN_WAIT: token_wait_q <= pwdata[15:0];
				sdspi_pkg::REG_BUSY_WAIT:  busy_wait_q  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			sdspi_pkg::REG_BLOCK_LEN:  prdata = {20'd0, block_len_q};
			sdspi_pkg::REG_TOKEN_WAIT: prdata = {16'd0, token_wait_q};
			sdspi_pkg::REG_BUSY_WAIT:  prdata = busy_wait_q;
			default:                   prdata = 32'd0;
		endcase
	end

	assign cfg.block_len        = block_len_q;
	assign cfg.token_wait_limit = token_wait_q;
	assign cfg.busy_wait_limit  = busy_wait_q;

endmodule

/* hdl/sdspi_step.sv */
// sdspi_step: request state and the per-item step logic (one SPI byte per item).
// Depends on sdspi_pkg; driven from the input stage of the top level.
module sdspi_step (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  sdspi_pkg::item_t item,
	input  sdspi_pkg::cfg_t  cfg,
	output sdspi_pkg::res_t  res
);

	typedef enum logic [3:0] {
		PH_IDLE, PH_CMD, PH_RESP, PH_R2, PH_BUSY, PH_TOKEN, PH_RDATA,
		PH_RCRC, PH_WTOKEN, PH_WDATA, PH_WCRC, PH_WRESP, PH_TAIL
	} phase_t;

	phase_t      phase_q, n_phase;
	logic [15:0] bc_q, n_bc;
	logic [31:0] busy_q, n_busy;
	logic [5:0]  cmd_q, n_cmd;
	logic [31:0] arg_q, n_arg;
	logic [8:0]  blocks_q, n_blocks;
	logic [15:0] resp_q, n_resp;
	logic [2:0]  err_q, n_err;
	logic        stop_q, n_stop;

	logic        is_read, is_r1b;
	logic        do_rfinish, do_complete, do_finish, do_frame;
	logic [8:0]  blk_sat, blk_dec;
	logic [4:0]  dresp;

	function automatic logic [7:0] frame_byte(input logic [15:0] idx, input logic [5:0] c,
		input logic [31:0] a);
		case (idx)
			16'd0:   frame_byte = sdspi_pkg::CMD_START | {2'b00, c};
			16'd1:   frame_byte = a[31:24];
			16'd2:   frame_byte = a[23:16];
			16'd3:   frame_byte = a[15:8];
			16'd4:   frame_byte = a[7:0];
			default: frame_byte = sdspi_pkg::CMD_CRC;
		endcase
	endfunction

	assign is_read = (cmd_q == sdspi_pkg::CMD9) || (cmd_q == sdspi_pkg::CMD10) ||
		(cmd_q == sdspi_pkg::CMD17) || (cmd_q == sdspi_pkg::CMD18);
	assign is_r1b = (cmd_q == sdspi_pkg::CMD12) || (cmd_q == sdspi_pkg::CMD28) ||
		(cmd_q == sdspi_pkg::CMD29) || (cmd_q == sdspi_pkg::CMD38);
	assign blk_sat = (item.block_count > 9'(sdspi_pkg::MAX_BLOCKS)) ?
		9'(sdspi_pkg::MAX_BLOCKS) : item.block_count;
	assign blk_dec = (blocks_q != 9'd0) ? blocks_q - 9'd1 : blocks_q;
	assign dresp   = item.miso_byte[4:0];

	always_comb begin
		n_phase  = phase_q;
		n_bc     = bc_q;
		n_busy   = busy_q;
		n_cmd    = cmd_q;
		n_arg    = arg_q;
		n_blocks = blocks_q;
		n_resp   = resp_q;
		n_err    = err_q;
		n_stop   = stop_q;
		do_rfinish  = 1'b0;
		do_complete = 1'b0;
		do_finish   = 1'b0;
		do_frame    = 1'b0;
		res = '0;
		res.mosi_byte = sdspi_pkg::BYTE_FILL;

		if (item.op == sdspi_pkg::OP_START) begin
			n_cmd    = item.cmd;
			n_arg    = item.arg;
			n_blocks = blk_sat;
			n_err    = sdspi_pkg::ST_OK;
			n_resp   = 16'd0;
			n_stop   = 1'b0;
			n_busy   = 32'd0;
			if (item.cmd == sdspi_pkg::CMD24 && blk_sat == 9'd0)
				do_finish = 1'b1;
			else
				do_frame = 1'b1;
		end else begin
			case (phase_q)
				PH_CMD: begin
					n_bc = bc_q + 16'd1;
					if (n_bc < 16'd6) begin
						res.mosi_byte = frame_byte(n_bc, cmd_q, arg_q);
						res.cs_active = 1'b1;
					end else begin
						n_phase = PH_RESP;
						n_bc    = 16'd0;
						res.cs_active = 1'b1;
					end
				end
				PH_RESP: begin
					if (item.miso_byte != sdspi_pkg::BYTE_FILL) begin
						n_resp = {8'd0, item.miso_byte};
						if (is_read) begin
							if (blocks_q == 9'd0)
								do_rfinish = 1'b1;
							else begin
								n_phase = PH_TOKEN;
								n_bc    = 16'd0;
								res.cs_active = 1'b1;
							end
						end else if (cmd_q == sdspi_pkg::CMD24) begin
							n_phase = PH_WTOKEN;
							res.mosi_byte = sdspi_pkg::TOKEN_START;
							res.cs_active = 1'b1;
						end else if (is_r1b) begin
							n_phase = PH_BUSY;
							n_busy  = 32'd0;
							res.cs_active = 1'b1;
						end else if (cmd_q == sdspi_pkg::CMD13) begin
							n_phase = PH_R2;
							res.cs_active = 1'b1;
						end else
							do_complete = 1'b1;
					end else begin
						n_bc = bc_q + 16'd1;
						if (n_bc >= 16'(sdspi_pkg::RESP_WAIT_BYTES)) begin
							n_resp = {8'd0, sdspi_pkg::BYTE_FILL};
							if (err_q == sdspi_pkg::ST_OK) n_err = sdspi_pkg::ST_NO_RESP;
							if (is_read) do_rfinish = 1'b1;
							else do_complete = 1'b1;
						end else
							res.cs_active = 1'b1;
					end
				end
				PH_R2: begin
					n_resp = {resp_q[7:0], item.miso_byte};
					do_complete = 1'b1;
				end
				PH_BUSY: begin
					if (item.miso_byte == sdspi_pkg::BYTE_ZERO) begin
						n_busy = busy_q + 32'd1;
						if (cfg.busy_wait_limit != 32'd0 && n_busy >= cfg.busy_wait_limit) begin
							if (err_q == sdspi_pkg::ST_OK) n_err = sdspi_pkg::ST_BUSY_TO;
							do_complete = 1'b1;
						end else
							res.cs_active = 1'b1;
					end else begin
						if (cmd_q == sdspi_pkg::CMD24) n_blocks = blk_dec;
						do_complete = 1'b1;
					end
				end
				PH_TOKEN: begin
					if (item.miso_byte == sdspi_pkg::TOKEN_START) begin
						n_phase = (cfg.block_len != 12'd0) ? PH_RDATA : PH_RCRC;
						n_bc    = 16'd0;
						res.cs_active = 1'b1;
					end else begin
						n_bc = bc_q + 16'd1;
						if (n_bc >= cfg.token_wait_limit) begin
							if (err_q == sdspi_pkg::ST_OK) n_err = sdspi_pkg::ST_NO_TOKEN;
							do_rfinish = 1'b1;
						end else
							res.cs_active = 1'b1;
					end
				end
				PH_RDATA: begin
					res.rd_valid = 1'b1;
					res.rd_byte  = item.miso_byte;
					n_bc = bc_q + 16'd1;
					if (n_bc >= {4'd0, cfg.block_len}) begin
						n_phase = PH_RCRC;
						n_bc    = 16'd0;
					end
					res.cs_active = 1'b1;
				end
				PH_RCRC: begin
					n_bc = bc_q + 16'd1;
					if (n_bc < 16'd2)
						res.cs_active = 1'b1;
					else begin
						n_blocks = blk_dec;
						if (blk_dec == 9'd0)
							do_rfinish = 1'b1;
						else begin
							n_phase = PH_TOKEN;
							n_bc    = 16'd0;
							res.cs_active = 1'b1;
						end
					end
				end
				PH_WTOKEN: begin
					n_bc = 16'd0;
					res.cs_active = 1'b1;
					if (cfg.block_len != 12'd0) begin
						n_phase = PH_WDATA;
						res.mosi_byte   = item.wdata_byte;
						res.wdata_taken = 1'b1;
					end else begin
						n_phase = PH_WCRC;
						res.mosi_byte = sdspi_pkg::BYTE_ZERO;
					end
				end
				PH_WDATA: begin
					n_bc = bc_q + 16'd1;
					res.cs_active = 1'b1;
					if (n_bc < {4'd0, cfg.block_len}) begin
						res.mosi_byte   = item.wdata_byte;
						res.wdata_taken = 1'b1;
					end else begin
						n_phase = PH_WCRC;
						n_bc    = 16'd0;
						res.mosi_byte = sdspi_pkg::BYTE_ZERO;
					end
				end
				PH_WCRC: begin
					n_bc = bc_q + 16'd1;
					res.cs_active = 1'b1;
					if (n_bc < 16'd2)
						res.mosi_byte = sdspi_pkg::BYTE_ZERO;
					else
						n_phase = PH_WRESP;
				end
				PH_WRESP: begin
					if (dresp == sdspi_pkg::DRESP_CRC) begin
						if (err_q == sdspi_pkg::ST_OK) n_err = sdspi_pkg::ST_CRC_REJ;
						do_complete = 1'b1;
					end else if (dresp == sdspi_pkg::DRESP_WERR) begin
						if (err_q == sdspi_pkg::ST_OK) n_err = sdspi_pkg::ST_WR_ERR;
						do_complete = 1'b1;
					end else begin
						n_phase = PH_BUSY;
						n_busy  = 32'd0;
						res.cs_active = 1'b1;
					end
				end
				PH_TAIL: begin
					if (cmd_q == sdspi_pkg::CMD24 && err_q == sdspi_pkg::ST_OK &&
						blocks_q != 9'd0) begin
						n_arg    = arg_q + sdspi_pkg::ADDR_STEP;
						do_frame = 1'b1;
					end else
						do_finish = 1'b1;
				end
				default: begin
					n_phase = PH_IDLE;
				end
			endcase
		end

		// multi-block read closes with CMD12 while chip select stays low
		if (do_rfinish) begin
			if (cmd_q == sdspi_pkg::CMD18 && !stop_q) begin
				n_stop   = 1'b1;
				n_cmd    = sdspi_pkg::CMD12;
				n_arg    = 32'd0;
				do_frame = 1'b1;
			end else
				do_complete = 1'b1;
		end
		if (do_complete) begin
			n_phase = PH_TAIL;
			res.mosi_byte = sdspi_pkg::BYTE_FILL;
			res.cs_active = 1'b0;
		end
		if (do_frame) begin
			n_phase = PH_CMD;
			n_bc    = 16'd0;
			res.mosi_byte = frame_byte(16'd0, n_cmd, n_arg);
			res.cs_active = 1'b1;
		end
		if (do_finish) begin
			n_phase = PH_IDLE;
			n_stop  = 1'b0;
			res.done_res  = 1'b1;
			res.status    = n_err;
			res.response  = n_resp;
			res.mosi_byte = sdspi_pkg::BYTE_FILL;
			res.cs_active = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			bc_q     <= 16'd0;
			busy_q   <= 32'd0;
			cmd_q    <= 6'd0;
			arg_q    <= 32'd0;
			blocks_q <= 9'd0;
			resp_q   <= 16'd0;
			err_q    <= sdspi_pkg::ST_OK;
			stop_q   <= 1'b0;
		end else if (en) begin
			phase_q  <= n_phase;
			bc_q     <= n_bc;
			busy_q   <= n_busy;
			cmd_q    <= n_cmd;
			arg_q    <= n_arg;
			blocks_q <= n_blocks;
			resp_q   <= n_resp;
			err_q    <= n_err;
			stop_q   <= n_stop;
		end
	end

	a_stop_only_cmd12: assert property (@(posedge clk) disable iff (!arst_n)
		(stop_q && phase_q != PH_IDLE) |-> (cmd_q == sdspi_pkg::CMD12))
		else $error("stop pending without CMD12");

	a_blocks_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		blocks_q <= 9'(sdspi_pkg::MAX_BLOCKS))
		else $error("block count above limit");

	a_frame_len: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_CMD) |-> (bc_q < 16'd6))
		else $error("command frame overrun");

endmodule

/* hdl/sd_spi_command_engine.sv */
// sd_spi_command_engine: top level, input stage, result register and APB port.
// Depends on sdspi_pkg, sdspi_cfg and sdspi_step.
//
// Usage: each item on the input channel (in_valid/in_ready) is either a start
// request (op = 0: cmd, arg, block_count) or one finished SPI byte slot
// (op = 1: miso_byte received, wdata_byte offered). Every item yields exactly
// one result on the output channel (out_valid/out_ready): the byte to shift
// next, chip select, read payload strobe, write payload consumption and, at
// the end of a request, done_res with status and response.
// Each item passes the input register, then the result register. Throughput:
// one item per clock while the receiver is not stalled; the step logic is a
// single pass over the request state, so the SPI byte transfer sets the real
// pace.
// Reset (arst_n low) returns the engine to idle with registers at defaults
// (block_len 512, token_wait_limit 8192, busy_wait_limit 0).
// A stalled receiver holds the result register; one more item may wait in
// the input register, after which in_ready drops until out_ready returns.
// Registers sit at byte addresses 0, 4 and 8; write them only while idle.
module sd_spi_command_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [5:0]  cmd,
	input  logic [31:0] arg,
	input  logic [8:0]  block_count,
	input  logic [7:0]  miso_byte,
	input  logic [7:0]  wdata_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  mosi_byte,
	output logic        cs_active,
	output logic        rd_valid,
	output logic [7:0]  rd_byte,
	output logic        wdata_taken,
	output logic        done_res,
	output logic [2:0]  status,
	output logic [15:0] response,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	sdspi_pkg::cfg_t  cfg;
	sdspi_pkg::item_t item_s1;
	sdspi_pkg::res_t  step_res, res_s2;
	logic             valid_s1, valid_s2;
	logic             advance, step_en;

	assign advance  = !valid_s2 || out_ready;
	assign step_en  = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.op          <= op;
			item_s1.cmd         <= cmd;
			item_s1.arg         <= arg;
			item_s1.block_count <= block_count;
			item_s1.miso_byte   <= miso_byte;
			item_s1.wdata_byte  <= wdata_byte;
		end
	end

	sdspi_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sdspi_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (step_en),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (advance)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (step_en)
			res_s2 <= step_res;
	end

	assign out_valid   = valid_s2;
	assign mosi_byte   = res_s2.mosi_byte;
	assign cs_active   = res_s2.cs_active;
	assign rd_valid    = res_s2.rd_valid;
	assign rd_byte     = res_s2.rd_byte;
	assign wdata_taken = res_s2.wdata_taken;
	assign done_res    = res_s2.done_res;
	assign status      = res_s2.status;
	assign response    = res_s2.response;

	a_step_loads: assert property (@(posedge clk) disable iff (!arst_n)
		step_en |=> valid_s2)
		else $error("stepped item lost before result register");

	a_done_cs_off: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.done_res) |-> !res_s2.cs_active)
		else $error("done with chip select held");

	a_rd_wr_excl: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(res_s2.rd_valid && res_s2.wdata_taken))
		else $error("read and write payload in one slot");

	a_status_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !res_s2.done_res) |-> (res_s2.status == sdspi_pkg::ST_OK))
		else $error("status outside done item");

endmodule
